>>> rtl/grc_pkg.sv
// Shared types, constants and codes of the grid raycast column block.
`default_nettype none
package grc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAP_SIDE   = 64;
	localparam int MAP_W      = 6;
	localparam int MAP_DEPTH  = MAP_SIDE * MAP_SIDE;
	localparam int ADDR_W     = 2 * MAP_W;
	localparam int CELL_W     = MAP_W + 2;
	localparam int DIV_NUM_W  = 40;
	localparam int DIV_DEN_W  = 32;
	localparam int DIV_CNT_W  = 6;
	localparam int RAY_W      = 32;
	localparam int CAM_W      = 30;
	localparam int SD_W       = 41;
	localparam int DD_W       = 33;
	localparam int PROD_W     = 48;
	localparam int FX_W       = FRAC_BITS + 1;
	localparam int DM_W       = 23;

	localparam logic [DIV_CNT_W-1:0] ITER_CAM  = 6'd28;
	localparam logic [DIV_CNT_W-1:0] ITER_SD   = 6'd33;
	localparam logic [DIV_CNT_W-1:0] ITER_DIST = 6'd39;
	localparam logic [DIV_CNT_W-1:0] ITER_LH   = 6'd28;

	localparam logic [1:0] STATUS_HIT   = 2'd0;
	localparam logic [1:0] STATUS_WRITE = 2'd1;
	localparam logic [1:0] STATUS_MISS  = 2'd2;

	localparam logic [2:0] REG_POS_X         = 3'd0;
	localparam logic [2:0] REG_POS_Y         = 3'd1;
	localparam logic [2:0] REG_DIR_X         = 3'd2;
	localparam logic [2:0] REG_DIR_Y         = 3'd3;
	localparam logic [2:0] REG_PLANE_X       = 3'd4;
	localparam logic [2:0] REG_PLANE_Y       = 3'd5;
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd6;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd7;

	localparam logic signed [17:0] RST_DIR_X   = 18'sd65536;
	localparam logic signed [17:0] RST_PLANE_Y = 18'sd43254;
	localparam logic [11:0]        RST_WIDTH   = 12'd640;
	localparam logic [11:0]        RST_HEIGHT  = 12'd480;

	typedef struct packed {
		logic        command;
		logic [10:0] column;
		logic [5:0]  cell_x;
		logic [5:0]  cell_y;
		logic        wall_bit;
	} grc_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] wall_distance;
		logic        hit_side;
		logic [5:0]  hit_cell_x;
		logic [5:0]  hit_cell_y;
		logic [15:0] wall_height;
		logic [10:0] draw_first_row;
		logic [11:0] draw_end_row;
		logic [15:0] wall_fraction;
	} grc_result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAPWR,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL_X,
		ST_MUL_Y,
		ST_RAY_Y,
		ST_RAY_CHK,
		ST_STEP,
		ST_PROBE,
		ST_LH_SEL,
		ST_MUL_W,
		ST_FIN,
		ST_MISS
	} grc_state_t;

	typedef enum logic [2:0] {
		DIV_CAM,
		DIV_SDX,
		DIV_DDX,
		DIV_SDY,
		DIV_DDY,
		DIV_DIST,
		DIV_LH
	} grc_div_op_t;

	typedef enum logic [1:0] {
		MUL_RAY_X,
		MUL_RAY_Y,
		MUL_WALL
	} grc_mul_sel_t;

	typedef struct packed {
		logic         clr_en;
		logic         accept;
		logic         div_go;
		logic         div_latch;
		grc_div_op_t  div_op;
		logic         mul_go;
		grc_mul_sel_t mul_sel;
		logic         ray_x;
		logic         ray_y;
		logic         step;
		logic         lh_max;
		logic         out_load;
		logic [1:0]   out_status;
	} grc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic ray_zero;
		logic oob;
		logic wall;
		logic last_step;
		logic d_zero;
	} grc_sts_t;

endpackage
`default_nettype wire

>>> rtl/grid_raycast_column.sv
// Top level of the grid raycast column block: controller plus datapath.
//
//  channel   direction  handshake                 payload
//  item      in         start & !busy             grc_item_t (command, column, cell, wall bit)
//  result    out        done, one cycle, no stall grc_result_t
//  config    in         cfg_write                 cfg_index selects register, cfg_data
//
// A map write returns its result through the map-write state and the registered done strobe.
// A cast that hits walks the DDA through the step and probe states after it is taken
// (MAX_STEPS bounds the walk): up to seven divisions on the one restoring
// divider, one quotient bit a cycle (28 to 39 bits each), dominate its time.
// After reset busy stays high while the bitmap is cleared.
// The receiver cannot stall; done is a single-cycle strobe.
`default_nettype none
module grid_raycast_column #(
	parameter int MAX_STEPS = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire grc_pkg::grc_item_t    item,
	output logic                       busy,
	output logic                       done,
	output grc_pkg::grc_result_t       result,
	input  wire logic                  cfg_write,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [21:0]           cfg_data
);

	// command and status buses between the two halves
	grc_pkg::grc_cmd_t cmd;
	grc_pkg::grc_sts_t sts;

	// sequence clearing, map writes and the cast of one column
	grc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (item.command),
		.busy    (busy),
		.cmd     (cmd),
		.sts     (sts)
	);

	// hold the camera, the bitmap, the divider and the walk registers
	grc_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule
`default_nettype wire

>>> rtl/grc_div.sv
// Restoring divider, one quotient bit per cycle, numerator aligned at the top.
`default_nettype none
module grc_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            go,
	input  wire logic [grc_pkg::DIV_NUM_W-1:0]   num,
	input  wire logic [grc_pkg::DIV_DEN_W-1:0]   den,
	input  wire logic [grc_pkg::DIV_CNT_W-1:0]   iters,
	output logic                                 done,
	output logic [grc_pkg::DIV_NUM_W-1:0]        quo
);

	localparam int NW = grc_pkg::DIV_NUM_W;
	localparam int DW = grc_pkg::DIV_DEN_W;

	logic [NW-1:0]                  nq_q;
	logic [DW-1:0]                  rem_q;
	logic [DW-1:0]                  den_q;
	logic [grc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic [DW:0]                    trial;
	logic [DW+1:0]                  diff;
	logic                           fits;

	assign trial = {rem_q, nq_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign fits  = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= iters;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == grc_pkg::DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			// shift in the next numerator bit, subtract when it fits
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			nq_q  <= {nq_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule
`default_nettype wire

>>> rtl/grc_dp.sv
// Datapath: camera registers, wall bitmap, ray setup, DDA walk and result assembly.
`default_nettype none
module grc_dp #(
	parameter int MAX_STEPS = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire grc_pkg::grc_cmd_t     cmd,
	output grc_pkg::grc_sts_t          sts,
	input  wire grc_pkg::grc_item_t    item,
	input  wire logic                  cfg_write,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [21:0]           cfg_data,
	output logic                       done,
	output grc_pkg::grc_result_t       result
);

	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int FB     = grc_pkg::FRAC_BITS;
	localparam int MW     = grc_pkg::MAP_W;
	localparam int CW     = grc_pkg::CELL_W;
	localparam int RW     = grc_pkg::RAY_W;
	localparam int SW     = grc_pkg::SD_W;
	localparam int DDW    = grc_pkg::DD_W;
	localparam int NW     = grc_pkg::DIV_NUM_W;
	localparam int DMW    = grc_pkg::DM_W;
	localparam logic signed [grc_pkg::CAM_W-1:0] ONE_CAM = grc_pkg::CAM_W'(1 << FB);
	localparam logic [grc_pkg::FX_W-1:0]         ONE_FX  = grc_pkg::FX_W'(1 << FB);
	localparam logic signed [CW-1:0]             CELL_P1 = CW'(1);
	localparam logic signed [CW-1:0]             CELL_M1 = '1;

	// configuration registers
	logic [21:0]        pos_x_q, pos_y_q;
	logic signed [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [11:0]        width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			dir_x_q   <= grc_pkg::RST_DIR_X;
			dir_y_q   <= '0;
			plane_x_q <= '0;
			plane_y_q <= grc_pkg::RST_PLANE_Y;
			width_q   <= grc_pkg::RST_WIDTH;
			height_q  <= grc_pkg::RST_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				grc_pkg::REG_POS_X:         pos_x_q   <= cfg_data;
				grc_pkg::REG_POS_Y:         pos_y_q   <= cfg_data;
				grc_pkg::REG_DIR_X:         dir_x_q   <= cfg_data[17:0];
				grc_pkg::REG_DIR_Y:         dir_y_q   <= cfg_data[17:0];
				grc_pkg::REG_PLANE_X:       plane_x_q <= cfg_data[17:0];
				grc_pkg::REG_PLANE_Y:       plane_y_q <= cfg_data[17:0];
				grc_pkg::REG_SCREEN_WIDTH:  width_q   <= cfg_data[11:0];
				grc_pkg::REG_SCREEN_HEIGHT: height_q  <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// held transaction
	grc_pkg::grc_item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.accept)
			item_q <= item;
	end

	// walk and arithmetic registers
	logic signed [grc_pkg::CAM_W-1:0] cam_q;
	logic signed [RW-1:0]             rx_q, ry_q;
	logic [grc_pkg::PROD_W-1:0]       prod_q;
	logic [SW-1:0]                    sdx_q, sdy_q;
	logic [DDW-1:0]                   ddx_q, ddy_q;
	logic signed [CW-1:0]             mx_q, my_q;
	logic                             side_q;
	logic                             oob_q;
	logic [STEP_W-1:0]                step_cnt_q;
	logic [31:0]                      d_q;
	logic [15:0]                      lh_q;

	// magnitudes and first-boundary fractions
	logic [RW-1:0]               ax, ay;
	logic                        act_x, act_y;
	logic [grc_pkg::FX_W-1:0]    fx, fy;

	assign ax    = rx_q[RW-1] ? RW'(-rx_q) : RW'(rx_q);
	assign ay    = ry_q[RW-1] ? RW'(-ry_q) : RW'(ry_q);
	assign act_x = (rx_q != '0);
	assign act_y = (ry_q != '0);
	assign fx    = rx_q[RW-1] ? {1'b0, pos_x_q[FB-1:0]} : ONE_FX - {1'b0, pos_x_q[FB-1:0]};
	assign fy    = ry_q[RW-1] ? {1'b0, pos_y_q[FB-1:0]} : ONE_FX - {1'b0, pos_y_q[FB-1:0]};

	// distance numerator: boundary crossed minus camera position
	logic [MW:0]          hit_line;
	logic [21:0]          hit_pos;
	logic signed [24:0]   dist_diff;
	logic [DMW-1:0]       dmag;

	assign hit_line  = side_q ? ((MW+1)'(my_q[MW-1:0]) + (MW+1)'(ry_q[RW-1]))
	                          : ((MW+1)'(mx_q[MW-1:0]) + (MW+1)'(rx_q[RW-1]));
	assign hit_pos   = side_q ? pos_y_q : pos_x_q;
	assign dist_diff = $signed({2'b00, hit_line, {FB{1'b0}}}) - $signed({3'b000, hit_pos});
	assign dmag      = dist_diff[24] ? DMW'(-dist_diff) : dist_diff[DMW-1:0];

	// divider operand select
	logic [NW-1:0]                  div_num;
	logic [grc_pkg::DIV_DEN_W-1:0]  div_den;
	logic [grc_pkg::DIV_CNT_W-1:0]  div_iters;
	logic [11:0]                    w_eff;
	logic                           div_done;
	logic [NW-1:0]                  div_quo;

	assign w_eff = (width_q == '0) ? 12'd1 : width_q;

	always_comb begin
		unique case (cmd.div_op)
			grc_pkg::DIV_CAM: begin
				div_num   = {item_q.column, 29'd0};
				div_den   = {20'd0, w_eff};
				div_iters = grc_pkg::ITER_CAM;
			end
			grc_pkg::DIV_SDX: begin
				div_num   = {fx, 23'd0};
				div_den   = ax;
				div_iters = grc_pkg::ITER_SD;
			end
			grc_pkg::DIV_DDX: begin
				div_num   = {1'b1, 39'd0};
				div_den   = ax;
				div_iters = grc_pkg::ITER_SD;
			end
			grc_pkg::DIV_SDY: begin
				div_num   = {fy, 23'd0};
				div_den   = ay;
				div_iters = grc_pkg::ITER_SD;
			end
			grc_pkg::DIV_DDY: begin
				div_num   = {1'b1, 39'd0};
				div_den   = ay;
				div_iters = grc_pkg::ITER_SD;
			end
			grc_pkg::DIV_DIST: begin
				div_num   = {dmag, 17'd0};
				div_den   = side_q ? ay : ax;
				div_iters = grc_pkg::ITER_DIST;
			end
			grc_pkg::DIV_LH: begin
				div_num   = {height_q, 28'd0};
				div_den   = d_q;
				div_iters = grc_pkg::ITER_LH;
			end
			default: begin
				div_num   = '0;
				div_den   = '0;
				div_iters = '0;
			end
		endcase
	end

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.iters  (div_iters),
		.done   (div_done),
		.quo    (div_quo)
	);

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [64:0] mul_p;

	always_comb begin
		unique case (cmd.mul_sel)
			grc_pkg::MUL_RAY_X: begin
				mul_a = 33'(plane_x_q);
				mul_b = 32'(cam_q);
			end
			grc_pkg::MUL_RAY_Y: begin
				mul_a = 33'(plane_y_q);
				mul_b = 32'(cam_q);
			end
			grc_pkg::MUL_WALL: begin
				mul_a = $signed({1'b0, d_q});
				mul_b = side_q ? rx_q : ry_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// one DDA step
	logic                 step_x;
	logic signed [CW-1:0] nmx, nmy;
	logic                 oob_n;

	assign step_x = act_x && (!act_y || (sdx_q < sdy_q));
	assign nmx    = step_x ? (mx_q + (rx_q[RW-1] ? CELL_M1 : CELL_P1)) : mx_q;
	assign nmy    = step_x ? my_q : (my_q + (ry_q[RW-1] ? CELL_M1 : CELL_P1));
	assign oob_n  = nmx[CW-1] || nmy[CW-1]
	             || (nmx[CW-2:0] >= (CW-1)'(grc_pkg::MAP_SIDE))
	             || (nmy[CW-2:0] >= (CW-1)'(grc_pkg::MAP_SIDE));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mx_q <= CW'(pos_x_q[FB +: MW]);
			my_q <= CW'(pos_y_q[FB +: MW]);
		end else if (cmd.step) begin
			mx_q   <= nmx;
			my_q   <= nmy;
			side_q <= !step_x;
			oob_q  <= oob_n;
			if (step_x)
				sdx_q <= sdx_q + SW'(ddx_q);
			else
				sdy_q <= sdy_q + SW'(ddy_q);
		end else if (cmd.div_latch) begin
			unique case (cmd.div_op)
				grc_pkg::DIV_CAM:  cam_q <= $signed({2'b00, div_quo[27:0]}) - ONE_CAM;
				grc_pkg::DIV_SDX:  sdx_q <= SW'(div_quo[DDW-1:0]);
				grc_pkg::DIV_DDX:  ddx_q <= div_quo[DDW-1:0];
				grc_pkg::DIV_SDY:  sdy_q <= SW'(div_quo[DDW-1:0]);
				grc_pkg::DIV_DDY:  ddy_q <= div_quo[DDW-1:0];
				grc_pkg::DIV_DIST: d_q   <= (div_quo[NW-1:32] != '0) ? '1 : div_quo[31:0];
				grc_pkg::DIV_LH:   lh_q  <= (div_quo[NW-1:16] != '0) ? '1 : div_quo[15:0];
				default: ;
			endcase
		end else if (cmd.lh_max) begin
			lh_q <= '1;
		end
		if (cmd.mul_go)
			prod_q <= mul_p[grc_pkg::PROD_W-1:0];
		if (cmd.ray_x)
			rx_q <= RW'(dir_x_q) + $signed(prod_q[FB +: RW]);
		if (cmd.ray_y)
			ry_q <= RW'(dir_y_q) + $signed(prod_q[FB +: RW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_cnt_q <= '0;
		else if (cmd.accept)
			step_cnt_q <= '0;
		else if (cmd.step)
			step_cnt_q <= step_cnt_q + 1'b1;
	end

	// wall bitmap with clearing pass after reset
	logic                         wall_mem [grc_pkg::MAP_DEPTH];
	logic [grc_pkg::ADDR_W-1:0]   clr_cnt_q;
	logic                         mem_we;
	logic [grc_pkg::ADDR_W-1:0]   mem_waddr;
	logic                         mem_wdata;
	logic [grc_pkg::ADDR_W-1:0]   mem_raddr;
	logic                         rd_q;

	assign mem_we    = cmd.clr_en || (cmd.accept && item.command);
	assign mem_waddr = cmd.clr_en ? clr_cnt_q : {item.cell_y, item.cell_x};
	assign mem_wdata = cmd.clr_en ? 1'b0 : item.wall_bit;
	assign mem_raddr = {nmy[MW-1:0], nmx[MW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_en)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			wall_mem[mem_waddr] <= mem_wdata;
		rd_q <= wall_mem[mem_raddr];
	end

	// result assembly
	logic [10:0] half_h;
	logic [14:0] half_lh;
	logic [10:0] first_row;
	logic [15:0] end_sum;
	logic [11:0] end_row;
	logic [15:0] frac;

	assign half_h    = height_q[11:1];
	assign half_lh   = lh_q[15:1];
	assign first_row = (15'(half_h) >= half_lh) ? (half_h - half_lh[10:0]) : '0;
	assign end_sum   = 16'(half_lh) + 16'(half_h);
	assign end_row   = (end_sum >= 16'(height_q)) ? height_q : end_sum[11:0];
	assign frac      = (side_q ? pos_x_q[FB-1:0] : pos_y_q[FB-1:0]) + prod_q[FB +: 16];

	grc_pkg::grc_result_t res_q;
	logic                 done_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q        <= '0;
			res_q.status <= cmd.out_status;
			if (cmd.out_status == grc_pkg::STATUS_HIT) begin
				res_q.wall_distance  <= d_q;
				res_q.hit_side       <= side_q;
				res_q.hit_cell_x     <= mx_q[MW-1:0];
				res_q.hit_cell_y     <= my_q[MW-1:0];
				res_q.wall_height    <= lh_q;
				res_q.draw_first_row <= first_row;
				res_q.draw_end_row   <= end_row;
				res_q.wall_fraction  <= frac;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.out_load;
	end

	assign done   = done_q;
	assign result = res_q;

	assign sts.clr_last  = &clr_cnt_q;
	assign sts.div_done  = div_done;
	assign sts.ray_zero  = !act_x && !act_y;
	assign sts.oob       = oob_q;
	assign sts.wall      = rd_q;
	assign sts.last_step = (step_cnt_q == STEP_W'(MAX_STEPS));
	assign sts.d_zero    = (d_q == '0);

`ifndef SYNTH
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");
	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |=> !div_done)
		else $error("divider finished in the cycle after launch");
`endif

endmodule
`default_nettype wire

>>> rtl/grc_ctrl.sv
// Controller state machine: sequences clearing, map writes, ray setup, walk and finish.
`default_nettype none
module grc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               command,
	output logic                    busy,
	output grc_pkg::grc_cmd_t       cmd,
	input  wire grc_pkg::grc_sts_t  sts
);

	grc_pkg::grc_state_t  state_q, state_d;
	grc_pkg::grc_div_op_t op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= grc_pkg::ST_CLEAR;
			op_q    <= grc_pkg::DIV_CAM;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			grc_pkg::ST_CLEAR:
				if (sts.clr_last)
					state_d = grc_pkg::ST_IDLE;
			grc_pkg::ST_IDLE:
				if (start) begin
					if (command) begin
						state_d = grc_pkg::ST_MAPWR;
					end else begin
						op_d    = grc_pkg::DIV_CAM;
						state_d = grc_pkg::ST_DIV_GO;
					end
				end
			grc_pkg::ST_MAPWR:   state_d = grc_pkg::ST_IDLE;
			grc_pkg::ST_DIV_GO:  state_d = grc_pkg::ST_DIV_WAIT;
			grc_pkg::ST_DIV_WAIT:
				if (sts.div_done) begin
					unique case (op_q)
						grc_pkg::DIV_CAM: state_d = grc_pkg::ST_MUL_X;
						grc_pkg::DIV_SDX: begin
							op_d    = grc_pkg::DIV_DDX;
							state_d = grc_pkg::ST_DIV_GO;
						end
						grc_pkg::DIV_DDX: begin
							op_d    = grc_pkg::DIV_SDY;
							state_d = grc_pkg::ST_DIV_GO;
						end
						grc_pkg::DIV_SDY: begin
							op_d    = grc_pkg::DIV_DDY;
							state_d = grc_pkg::ST_DIV_GO;
						end
						grc_pkg::DIV_DDY:  state_d = grc_pkg::ST_STEP;
						grc_pkg::DIV_DIST: state_d = grc_pkg::ST_LH_SEL;
						grc_pkg::DIV_LH:   state_d = grc_pkg::ST_MUL_W;
						default:           state_d = grc_pkg::ST_IDLE;
					endcase
				end
			grc_pkg::ST_MUL_X:   state_d = grc_pkg::ST_MUL_Y;
			grc_pkg::ST_MUL_Y:   state_d = grc_pkg::ST_RAY_Y;
			grc_pkg::ST_RAY_Y:   state_d = grc_pkg::ST_RAY_CHK;
			grc_pkg::ST_RAY_CHK:
				if (sts.ray_zero) begin
					state_d = grc_pkg::ST_MISS;
				end else begin
					op_d    = grc_pkg::DIV_SDX;
					state_d = grc_pkg::ST_DIV_GO;
				end
			grc_pkg::ST_STEP:    state_d = grc_pkg::ST_PROBE;
			grc_pkg::ST_PROBE:
				priority if (sts.oob) begin
					state_d = grc_pkg::ST_MISS;
				end else if (sts.wall) begin
					op_d    = grc_pkg::DIV_DIST;
					state_d = grc_pkg::ST_DIV_GO;
				end else if (sts.last_step) begin
					state_d = grc_pkg::ST_MISS;
				end else begin
					state_d = grc_pkg::ST_STEP;
				end
			grc_pkg::ST_LH_SEL:
				if (sts.d_zero) begin
					state_d = grc_pkg::ST_MUL_W;
				end else begin
					op_d    = grc_pkg::DIV_LH;
					state_d = grc_pkg::ST_DIV_GO;
				end
			grc_pkg::ST_MUL_W:   state_d = grc_pkg::ST_FIN;
			grc_pkg::ST_FIN:     state_d = grc_pkg::ST_IDLE;
			grc_pkg::ST_MISS:    state_d = grc_pkg::ST_IDLE;
			default:             state_d = grc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.div_op = op_q;
		unique case (state_q)
			grc_pkg::ST_CLEAR:    cmd.clr_en = 1'b1;
			grc_pkg::ST_IDLE:     cmd.accept = start;
			grc_pkg::ST_MAPWR: begin
				cmd.out_load   = 1'b1;
				cmd.out_status = grc_pkg::STATUS_WRITE;
			end
			grc_pkg::ST_DIV_GO:   cmd.div_go    = 1'b1;
			grc_pkg::ST_DIV_WAIT: cmd.div_latch = sts.div_done;
			grc_pkg::ST_MUL_X: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = grc_pkg::MUL_RAY_X;
			end
			grc_pkg::ST_MUL_Y: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = grc_pkg::MUL_RAY_Y;
				cmd.ray_x   = 1'b1;
			end
			grc_pkg::ST_RAY_Y:    cmd.ray_y  = 1'b1;
			grc_pkg::ST_RAY_CHK:  ;
			grc_pkg::ST_STEP:     cmd.step   = 1'b1;
			grc_pkg::ST_PROBE:    ;
			grc_pkg::ST_LH_SEL:   cmd.lh_max = sts.d_zero;
			grc_pkg::ST_MUL_W: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = grc_pkg::MUL_WALL;
			end
			grc_pkg::ST_FIN: begin
				cmd.out_load   = 1'b1;
				cmd.out_status = grc_pkg::STATUS_HIT;
			end
			grc_pkg::ST_MISS: begin
				cmd.out_load   = 1'b1;
				cmd.out_status = grc_pkg::STATUS_MISS;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != grc_pkg::ST_IDLE);

`ifndef SYNTH
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == grc_pkg::ST_DIV_WAIT))
		else $error("divider result arrived outside the wait state");
	a_cast_starts_cam: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !command) |=> (op_q == grc_pkg::DIV_CAM))
		else $error("cast did not begin with the camera offset division");
`endif

endmodule
`default_nettype wire
